/* sv/sha1_pkg.sv */
`timescale 1ns / 1ps

package sha1_pkg;

  typedef struct packed {
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] c;
    logic [31:0] d;
    logic [31:0] e;
  } sha1_abcde_t;

  localparam logic [31:0] H0 = 32'h6745_2301;
  localparam logic [31:0] H1 = 32'hEFCD_AB89;
  localparam logic [31:0] H2 = 32'h98BA_DCFE;
  localparam logic [31:0] H3 = 32'h1032_5476;
  localparam logic [31:0] H4 = 32'hC3D2_E1F0;

  localparam logic [31:0] K0 = 32'h5A82_7999;
  localparam logic [31:0] K1 = 32'h6ED9_EBA1;
  localparam logic [31:0] K2 = 32'h8F1B_BCDC;
  localparam logic [31:0] K3 = 32'hCA62_C1D6;

  localparam int ROUNDS = 80;
  localparam int RND_W = 7;

  localparam logic [31:0] PAD_MARKER = 32'h8000_0000;
  localparam logic [3:0] LEN_POS = 4'd14;

endpackage

/* sv/sha1_round.sv */
`timescale 1ns / 1ps

module sha1_round (
  input  sha1_pkg::sha1_abcde_t     rnd,
  input  logic [31:0]               w0,
  input  logic [31:0]               w2,
  input  logic [31:0]               w8,
  input  logic [31:0]               w13,
  input  logic [sha1_pkg::RND_W-1:0] idx,
  output sha1_pkg::sha1_abcde_t     rnd_nxt,
  output logic [31:0]               w_new
);

  logic [31:0] f;
  logic [31:0] k;
  logic [31:0] x;

  always_comb begin
    if (idx < sha1_pkg::RND_W'(20)) begin
      f = (rnd.b & rnd.c) | (~rnd.b & rnd.d);
      k = sha1_pkg::K0;
    end else if (idx < sha1_pkg::RND_W'(40)) begin
      f = rnd.b ^ rnd.c ^ rnd.d;
      k = sha1_pkg::K1;
    end else if (idx < sha1_pkg::RND_W'(60)) begin
      f = (rnd.b & rnd.c) | (rnd.b & rnd.d) | (rnd.c & rnd.d);
      k = sha1_pkg::K2;
    end else begin
      f = rnd.b ^ rnd.c ^ rnd.d;
      k = sha1_pkg::K3;
    end
  end

  always_comb begin
    rnd_nxt.a = {rnd.a[26:0], rnd.a[31:27]} + f + rnd.e + w0 + k;
    rnd_nxt.b = rnd.a;
    rnd_nxt.c = {rnd.b[1:0], rnd.b[31:2]};
    rnd_nxt.d = rnd.c;
    rnd_nxt.e = rnd.d;
  end

  assign x = w13 ^ w8 ^ w2 ^ w0;
  assign w_new = {x[30:0], x[31]};

endmodule

/* sv/sha1_hash_core.sv */
`timescale 1ns / 1ps
// A word that completes a block starts the 80 rounds, followed by the chain add.
// Input takes one word per cycle while filling; a full block waits on the single shared
// round unit. The final word adds padding pushes, one or two blocks of rounds, then
// five digest items, one per cycle while out_tready is high.
// Reset (rst_n low, synchronous): chaining value to the initial words, length and
// position cleared, core idle and ready; the same happens after the fifth digest item.

module sha1_hash_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [31:0] message_word
  input  logic [2:0]  in_tuser,   // [2:0] byte_count
  input  logic        in_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [31:0] digest_word
  output logic        out_tlast
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_PAD   = 3'd1;
  localparam logic [2:0] S_ROUND = 3'd2;
  localparam logic [2:0] S_FINAL = 3'd3;
  localparam logic [2:0] S_OUT   = 3'd4;

  logic [2:0]  state_r, state_nxt;
  logic [31:0] chain_r [5];
  logic [31:0] chain_nxt [5];
  logic [31:0] w_r [16];
  logic [31:0] w_nxt [16];
  sha1_pkg::sha1_abcde_t rnd_r, rnd_nxt, rnd_calc;
  logic [63:0] bitlen_r, bitlen_nxt;
  logic [3:0]  pos_r, pos_nxt;
  logic [sha1_pkg::RND_W-1:0] cnt_r, cnt_nxt;
  logic [2:0]  oidx_r, oidx_nxt;
  logic        pad_r, pad_nxt;
  logic        marker_r, marker_nxt;
  logic        hi_done_r, hi_done_nxt;
  logic        done_r, done_nxt;

  logic        push_en;
  logic [31:0] push_data;
  logic [31:0] w_new;
  logic [2:0]  bcnt;
  logic [31:0] last_word;

  sha1_round u_round (
    .rnd     (rnd_r),
    .w0      (w_r[0]),
    .w2      (w_r[2]),
    .w8      (w_r[8]),
    .w13     (w_r[13]),
    .idx     (cnt_r),
    .rnd_nxt (rnd_calc),
    .w_new   (w_new)
  );

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = (state_r == S_OUT);
  assign out_tdata  = chain_r[oidx_r];
  assign out_tlast  = (state_r == S_OUT) && (oidx_r == 3'd4);

  always_comb begin
    bcnt = (in_tuser inside {[3'd5:3'd7]}) ? 3'd4 : in_tuser;
    case (bcnt)
      3'd0:    last_word = 32'h8000_0000;
      3'd1:    last_word = {in_tdata[31:24], 24'h80_0000};
      3'd2:    last_word = {in_tdata[31:16], 16'h8000};
      3'd3:    last_word = {in_tdata[31:8], 8'h80};
      default: last_word = in_tdata;
    endcase
  end

  always_comb begin
    state_nxt   = state_r;
    chain_nxt   = chain_r;
    w_nxt       = w_r;
    rnd_nxt     = rnd_r;
    bitlen_nxt  = bitlen_r;
    pos_nxt     = pos_r;
    cnt_nxt     = cnt_r;
    oidx_nxt    = oidx_r;
    pad_nxt     = pad_r;
    marker_nxt  = marker_r;
    hi_done_nxt = hi_done_r;
    done_nxt    = done_r;
    push_en     = 1'b0;
    push_data   = '0;

    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          push_en = 1'b1;
          if (!in_tlast) begin
            push_data  = in_tdata;
            bitlen_nxt = bitlen_r + 64'd32;
          end else begin
            push_data  = last_word;
            bitlen_nxt = bitlen_r + {58'd0, bcnt, 3'd0};
            pad_nxt    = 1'b1;
            marker_nxt = (bcnt == 3'd4);
            state_nxt  = S_PAD;
          end
        end
      end
      S_PAD: begin
        push_en = 1'b1;
        if (marker_r) begin
          push_data  = sha1_pkg::PAD_MARKER;
          marker_nxt = 1'b0;
        end else if (hi_done_r) begin
          push_data = bitlen_r[31:0];
          done_nxt  = 1'b1;
        end else if (pos_r == sha1_pkg::LEN_POS) begin
          push_data   = bitlen_r[63:32];
          hi_done_nxt = 1'b1;
        end
      end
      S_ROUND: begin
        rnd_nxt = rnd_calc;
        for (int i = 0; i < 15; i++) w_nxt[i] = w_r[i+1];
        w_nxt[15] = w_new;
        cnt_nxt = cnt_r + sha1_pkg::RND_W'(1);
        if (cnt_r == sha1_pkg::RND_W'(sha1_pkg::ROUNDS - 1)) state_nxt = S_FINAL;
      end
      S_FINAL: begin
        chain_nxt[0] = chain_r[0] + rnd_r.a;
        chain_nxt[1] = chain_r[1] + rnd_r.b;
        chain_nxt[2] = chain_r[2] + rnd_r.c;
        chain_nxt[3] = chain_r[3] + rnd_r.d;
        chain_nxt[4] = chain_r[4] + rnd_r.e;
        if (!pad_r) state_nxt = S_IDLE;
        else if (done_r) state_nxt = S_OUT;
        else state_nxt = S_PAD;
      end
      S_OUT: begin
        if (out_tready) begin
          oidx_nxt = oidx_r + 3'd1;
          if (oidx_r == 3'd4) begin
            state_nxt    = S_IDLE;
            chain_nxt[0] = sha1_pkg::H0;
            chain_nxt[1] = sha1_pkg::H1;
            chain_nxt[2] = sha1_pkg::H2;
            chain_nxt[3] = sha1_pkg::H3;
            chain_nxt[4] = sha1_pkg::H4;
            bitlen_nxt   = '0;
            pos_nxt      = '0;
            oidx_nxt     = '0;
            pad_nxt      = 1'b0;
            marker_nxt   = 1'b0;
            hi_done_nxt  = 1'b0;
            done_nxt     = 1'b0;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase

    if (push_en) begin
      for (int i = 0; i < 15; i++) w_nxt[i] = w_r[i+1];
      w_nxt[15] = push_data;
      pos_nxt = pos_r + 4'd1;
      if (pos_r == 4'd15) begin
        state_nxt = S_ROUND;
        cnt_nxt   = '0;
        rnd_nxt   = '{a: chain_r[0], b: chain_r[1], c: chain_r[2],
                      d: chain_r[3], e: chain_r[4]};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      chain_r[0] <= sha1_pkg::H0;
      chain_r[1] <= sha1_pkg::H1;
      chain_r[2] <= sha1_pkg::H2;
      chain_r[3] <= sha1_pkg::H3;
      chain_r[4] <= sha1_pkg::H4;
      bitlen_r   <= '0;
      pos_r      <= '0;
      cnt_r      <= '0;
      oidx_r     <= '0;
      pad_r      <= 1'b0;
      marker_r   <= 1'b0;
      hi_done_r  <= 1'b0;
      done_r     <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      chain_r   <= chain_nxt;
      bitlen_r  <= bitlen_nxt;
      pos_r     <= pos_nxt;
      cnt_r     <= cnt_nxt;
      oidx_r    <= oidx_nxt;
      pad_r     <= pad_nxt;
      marker_r  <= marker_nxt;
      hi_done_r <= hi_done_nxt;
      done_r    <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    w_r   <= w_nxt;
    rnd_r <= rnd_nxt;
  end

  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(out_tvalid && in_tready))
    else $error("input ready while digest pending");

  a_ready_after_digest: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tready && out_tlast) |=> (in_tready && pos_r == 4'd0))
    else $error("core not cleared after last digest item");

  a_round_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_ROUND) |-> (cnt_r < sha1_pkg::RND_W'(sha1_pkg::ROUNDS)))
    else $error("round counter overrun");

  a_out_after_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (done_r && pos_r == 4'd0))
    else $error("digest before length pushed");

endmodule
